### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent assertions of the point store RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/psnn_pkg.sv
// ---------------------------------------------------------------------------
// Point store package
// Types, codes and widths shared by the point store and its memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psnn_pkg;

  localparam int CAPACITY_DEFAULT = 256;
  localparam int COORD_W          = 16;
  localparam int IDX_W            = 8;
  localparam int PARENT_W         = 8;
  localparam int FUNC_W           = 2;
  localparam int STATUS_W         = 2;
  localparam int SQ_W             = 2 * COORD_W;
  localparam int DIST_W           = SQ_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_NEAREST = 2'd1,
    FUNC_READ    = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_FWAIT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [PARENT_W-1:0]       parent;
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/psnn_ram.sv
// ---------------------------------------------------------------------------
// Point store memory
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psnn_ram
  import psnn_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEFAULT,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/point_store_nearest_neighbour.sv
// ---------------------------------------------------------------------------
// Point store with nearest-neighbour search
// Stores 2D points with parent links and finds the nearest stored point.
// ---------------------------------------------------------------------------
// A command is taken at a rising edge where start is high and busy is low.
// func selects insert, nearest query or read entry; x, y, parent_in and
// entry_index carry the operands. Each command gives one result, shown on
// status, index_out, parent_out, x_out and y_out for one cycle while done
// is high. The receiver cannot stall, so results must be taken as they come.
// Insert, a failed command and an unused code finish without leaving
// idle, so busy stays low; read entry and nearest query hold busy high
// while they run. A query reads the point memory once per stored entry
// through its single read port, feeding a three-stage distance pipeline,
// and then reads the winning entry again.
// Reset empties the store at once; the memory itself is not cleared, as
// entries at or above the fill count are never read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module point_store_nearest_neighbour
  import psnn_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [FUNC_W-1:0]          func,
  input  logic signed [COORD_W-1:0]  x,
  input  logic signed [COORD_W-1:0]  y,
  input  logic [PARENT_W-1:0]        parent_in,
  input  logic [IDX_W-1:0]           entry_index,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [IDX_W-1:0]           index_out,
  output logic [PARENT_W-1:0]        parent_out,
  output logic signed [COORD_W-1:0]  x_out,
  output logic signed [COORD_W-1:0]  y_out
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > IDX_W) ? CW : IDX_W;

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] best_idx;
  logic [DIST_W-1:0] best_dist;
  logic signed [COORD_W-1:0] qx, qy;

  // Distance pipeline: memory read, absolute differences, squares.
  logic          rd_scan;
  logic [AW-1:0] rd_idx;
  logic          a_valid;
  logic [AW-1:0] a_idx;
  logic [COORD_W-1:0] a_dx, a_dy;
  logic          b_valid;
  logic [AW-1:0] b_idx;
  logic [SQ_W-1:0] b_sqx, b_sqy;

  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        wr_data, rd_data;

  logic          accept, full, ei_ok;
  logic [MW-1:0] ei_w, cnt_w, best_w;
  logic signed [COORD_W:0] diff_x, diff_y;
  logic [DIST_W-1:0] cand_dist;

  status_t       res_status;
  logic [IDX_W-1:0] res_index;
  logic [PARENT_W-1:0] res_parent;
  logic signed [COORD_W-1:0] res_x, res_y;

  assign accept = start && !busy;
  assign full   = (count == CW'(CAPACITY));
  assign ei_w   = MW'(entry_index);
  assign cnt_w  = MW'(count);
  assign best_w = MW'(best_idx);
  assign ei_ok  = (ei_w < cnt_w);

  assign wr_data.x      = x;
  assign wr_data.y      = y;
  assign wr_data.parent = parent_in;

  psnn_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_NEAREST && count != '0) begin
            state_next = ST_SCAN;
          end else if (func == FUNC_READ && ei_ok) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_SCAN: begin
        if (CW'(scan_addr) == count - CW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_scan && !a_valid && !b_valid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_FWAIT;
      ST_FWAIT: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    busy    = 1'b1;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    unique case (state)
      ST_IDLE: begin
        busy    = 1'b0;
        wr_en   = accept && func == FUNC_INSERT && !full;
        rd_en   = accept && func == FUNC_READ && ei_ok;
        rd_addr = ei_w[AW-1:0];
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_addr;
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = best_idx;
      end
      default: begin
        rd_en   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Distance pipeline.
  assign diff_x    = {rd_data.x[COORD_W-1], rd_data.x} - {qx[COORD_W-1], qx};
  assign diff_y    = {rd_data.y[COORD_W-1], rd_data.y} - {qy[COORD_W-1], qy};
  assign cand_dist = {1'b0, b_sqx} + {1'b0, b_sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_scan <= 1'b0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      rd_scan <= (state == ST_SCAN);
      a_valid <= rd_scan;
      b_valid <= a_valid;
    end
    rd_idx <= scan_addr;
    a_idx  <= rd_idx;
    a_dx   <= diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
    a_dy   <= diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
    b_idx  <= a_idx;
    b_sqx  <= a_dx * a_dx;
    b_sqy  <= a_dy * a_dy;
    // The scan starts at entry zero, so that entry seeds the running best.
    // A later entry replaces it only when strictly nearer.
    if (b_valid && (b_idx == '0 || cand_dist < best_dist)) begin
      best_dist <= cand_dist;
      best_idx  <= b_idx;
    end
  end

  // Fill count, scan address and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_index  <= '0;
            res_parent <= '0;
            res_x      <= '0;
            res_y      <= '0;
            res_status <= STAT_OK;
            case (func)
              FUNC_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  res_status <= STAT_FULL;
                end else begin
                  res_index  <= cnt_w[IDX_W-1:0];
                  res_parent <= parent_in;
                  res_x      <= x;
                  res_y      <= y;
                  count      <= count + CW'(1);
                end
              end
              FUNC_NEAREST: begin
                qx        <= x;
                qy        <= y;
                scan_addr <= '0;
                if (count == '0) begin
                  done       <= 1'b1;
                  res_status <= STAT_EMPTY;
                end
              end
              FUNC_READ: begin
                res_index <= entry_index;
                if (!ei_ok) begin
                  done       <= 1'b1;
                  res_status <= STAT_EMPTY;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          scan_addr <= scan_addr + AW'(1);
        end
        ST_READ: begin
          done       <= 1'b1;
          res_status <= STAT_OK;
          res_parent <= rd_data.parent;
          res_x      <= rd_data.x;
          res_y      <= rd_data.y;
        end
        ST_FWAIT: begin
          done       <= 1'b1;
          res_status <= STAT_OK;
          res_index  <= best_w[IDX_W-1:0];
          res_parent <= rd_data.parent;
          res_x      <= rd_data.x;
          res_y      <= rd_data.y;
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  assign status     = res_status;
  assign index_out  = res_index;
  assign parent_out = res_parent;
  assign x_out      = res_x;
  assign y_out      = res_y;

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY), "fill count overflow")
  `ASSERT_IMPLIES(a_no_rw_clash, clk, rst, wr_en, !rd_en, "memory read and write together")
  `ASSERT_NEXT(a_insert_done, clk, rst, accept && func == FUNC_INSERT, done, "insert result missing")
  `ASSERT_IMPLIES(a_scan_range, clk, rst, state == ST_SCAN, CW'(scan_addr) < count, "scan beyond fill")
  `ASSERT_IMPLIES(a_idle_drained, clk, rst, state == ST_IDLE, !(rd_scan || a_valid || b_valid), "pipeline busy in idle")

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Point store nearest-neighbour testbench
// Sends insert, nearest query, read and unused-code transactions through the
// start/busy handshake. A directed table covers the edge cases first, then a
// long random run fills the store past capacity. Every done strobe is checked
// field by field against an in-order queue of predicted answers.
// ---------------------------------------------------------------------------
module tb_top;
  import psnn_pkg::*;

  localparam int STORE_DEPTH   = CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int CALM_ITEMS    = 150;
  localparam int DRAIN_AT      = 700;
  localparam int SETTLE_CYCLES = STORE_DEPTH + 40;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [PARENT_W-1:0]       parent;
    logic [IDX_W-1:0]          index;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [IDX_W-1:0]          index;
    logic [PARENT_W-1:0]       parent;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } answer_t;

  typedef struct packed {
    command_t cmd;
    logic     typed;
    answer_t  ans;
  } table_row_t;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      start       = 1'b0;
  logic [FUNC_W-1:0]         func        = '0;
  logic signed [COORD_W-1:0] x           = '0;
  logic signed [COORD_W-1:0] y           = '0;
  logic [PARENT_W-1:0]       parent_in   = '0;
  logic [IDX_W-1:0]          entry_index = '0;
  logic                      busy;
  logic                      done;
  logic [STATUS_W-1:0]       status;
  logic [IDX_W-1:0]          index_out;
  logic [PARENT_W-1:0]       parent_out;
  logic signed [COORD_W-1:0] x_out;
  logic signed [COORD_W-1:0] y_out;

  // Shadow copy of the point store.
  logic signed [COORD_W-1:0] pt_x      [STORE_DEPTH];
  logic signed [COORD_W-1:0] pt_y      [STORE_DEPTH];
  logic [PARENT_W-1:0]       pt_parent [STORE_DEPTH];
  int                        fill_count = 0;

  answer_t    pending_answers[$];
  table_row_t directed_rows[$];
  answer_t    oldest;
  int         mismatches  = 0;
  int         idle_pct    = 25;
  longint     cycle_count = 0;

  point_store_nearest_neighbour #(
    .CAPACITY(STORE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .x(x),
    .y(y),
    .parent_in(parent_in),
    .entry_index(entry_index),
    .done(done),
    .status(status),
    .index_out(index_out),
    .parent_out(parent_out),
    .x_out(x_out),
    .y_out(y_out)
  );

  always #5 clk = ~clk;

  function automatic answer_t predict_answer(command_t c);
    answer_t r;
    int      best;
    longint  best_d;
    longint  d;
    longint  dx;
    longint  dy;
    r = '0;
    case (c.func)
      FUNC_INSERT: begin
        if (fill_count >= STORE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pt_x[fill_count]      = c.x;
          pt_y[fill_count]      = c.y;
          pt_parent[fill_count] = c.parent;
          r.status = STAT_OK;
          r.index  = IDX_W'(fill_count);
          r.parent = c.parent;
          r.x      = c.x;
          r.y      = c.y;
          fill_count++;
        end
      end
      FUNC_NEAREST: begin
        if (fill_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          best   = 0;
          best_d = 0;
          for (int i = 0; i < fill_count; i++) begin
            dx = longint'(pt_x[i]) - longint'(c.x);
            dy = longint'(pt_y[i]) - longint'(c.y);
            d  = dx * dx + dy * dy;
            // Strictly smaller only, so the lowest index keeps a tie.
            if (i == 0 || d < best_d) begin
              best_d = d;
              best   = i;
            end
          end
          r.status = STAT_OK;
          r.index  = IDX_W'(best);
          r.parent = pt_parent[best];
          r.x      = pt_x[best];
          r.y      = pt_y[best];
        end
      end
      FUNC_READ: begin
        r.index = c.index;
        if (int'(c.index) >= fill_count) begin
          r.status = STAT_EMPTY;
        end else begin
          r.status = STAT_OK;
          r.parent = pt_parent[c.index];
          r.x      = pt_x[c.index];
          r.y      = pt_y[c.index];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [FUNC_W-1:0] f, int cx, int cy, int par, int idx,
                                  logic typed, logic [STATUS_W-1:0] st, int ri, int rp,
                                  int rx, int ry);
    table_row_t row;
    row.cmd.func   = f;
    row.cmd.x      = COORD_W'(cx);
    row.cmd.y      = COORD_W'(cy);
    row.cmd.parent = PARENT_W'(par);
    row.cmd.index  = IDX_W'(idx);
    row.typed      = typed;
    row.ans.status = st;
    row.ans.index  = IDX_W'(ri);
    row.ans.parent = PARENT_W'(rp);
    row.ans.x      = COORD_W'(rx);
    row.ans.y      = COORD_W'(ry);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Full-range values for half the picks, else extremes or a small cluster
  // near the origin so that distance ties turn up often.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        default: return 16'shffff;
      endcase
    end else if (r < 5) begin
      return COORD_W'(int'($urandom_range(0, 16)) - 8);
    end
    return COORD_W'($urandom());
  endfunction

  function automatic int unsigned idle_gap();
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      return $urandom_range(1, 4);
    end
    return 0;
  endfunction

  // Present one transaction and wait until it is accepted. The start line
  // is left high so that the next transaction can follow back to back.
  task automatic issue(input command_t c, input int unsigned gap, input logic typed,
                       input answer_t typed_ans);
    answer_t predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    func        <= c.func;
    x           <= c.x;
    y           <= c.y;
    parent_in   <= c.parent;
    entry_index <= c.index;
    do @(posedge clk); while (busy);
    predicted = predict_answer(c);
    pending_answers.insert(pending_answers.size(), typed ? typed_ans : predicted);
  endtask

  task automatic wait_for_answers();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        mismatches++;
      end else begin
        oldest = pending_answers[0];
        pending_answers.delete(0);
        if (status !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, status);
          mismatches++;
        end
        if (index_out !== oldest.index) begin
          $error("index_out: expected %0d, actual %0d", oldest.index, index_out);
          mismatches++;
        end
        if (parent_out !== oldest.parent) begin
          $error("parent_out: expected %0d, actual %0d", oldest.parent, parent_out);
          mismatches++;
        end
        if (x_out !== oldest.x) begin
          $error("x_out: expected %0d, actual %0d", oldest.x, x_out);
          mismatches++;
        end
        if (y_out !== oldest.y) begin
          $error("y_out: expected %0d, actual %0d", oldest.y, y_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    command_t    c;
    int unsigned pick;
    int unsigned k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty store, unused code, the coordinate extremes, distance ties and
    // reads past the fill count.
    add_row(FUNC_NEAREST, 0, 0, 0, 0, 1'b1, STAT_EMPTY, 0, 0, 0, 0);
    add_row(FUNC_READ, 0, 0, 0, 0, 1'b1, STAT_EMPTY, 0, 0, 0, 0);
    add_row(FUNC_READ, 0, 0, 0, 255, 1'b1, STAT_EMPTY, 255, 0, 0, 0);
    add_row(FUNC_UNUSED, -1, -1, 255, 255, 1'b1, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_INSERT, -32768, -32768, 0, 255, 1'b1, STAT_OK, 0, 0, -32768, -32768);
    add_row(FUNC_INSERT, 32767, 32767, 255, 0, 1'b1, STAT_OK, 1, 255, 32767, 32767);
    add_row(FUNC_READ, 0, 0, 0, 1, 1'b1, STAT_OK, 1, 255, 32767, 32767);
    add_row(FUNC_READ, 0, 0, 0, 0, 1'b1, STAT_OK, 0, 0, -32768, -32768);
    add_row(FUNC_READ, 0, 0, 0, 2, 1'b1, STAT_EMPTY, 2, 0, 0, 0);
    add_row(FUNC_NEAREST, 32767, 32767, 0, 0, 1'b0, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_NEAREST, -32768, 32767, 255, 255, 1'b0, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_NEAREST, 32767, -32768, 0, 0, 1'b0, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_INSERT, 0, 0, 8'h55, 0, 1'b1, STAT_OK, 2, 8'h55, 0, 0);
    add_row(FUNC_INSERT, 0, 0, 8'haa, 0, 1'b1, STAT_OK, 3, 8'haa, 0, 0);
    add_row(FUNC_NEAREST, 0, 0, 0, 0, 1'b0, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_NEAREST, 1, -1, 0, 0, 1'b0, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_INSERT, -1, 1, 2, 0, 1'b1, STAT_OK, 4, 2, -1, 1);
    add_row(FUNC_NEAREST, -32768, -32768, 0, 0, 1'b0, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_READ, 0, 0, 0, 3, 1'b0, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_UNUSED, 32767, -32768, 8'h5a, 8'ha5, 1'b1, STAT_OK, 0, 0, 0, 0);
    add_row(FUNC_NEAREST, 0, 1, 0, 0, 1'b0, STAT_OK, 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].cmd, idle_gap(), directed_rows[i].typed, directed_rows[i].ans);
    end
    wait_for_answers();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Idling changes in stretches, and stops for the closing part.
      if (n % 50 == 0) begin
        idle_pct = (n >= RANDOM_ITEMS - CALM_ITEMS) ? 0 : 25 * $urandom_range(0, 2);
      end
      if (n == DRAIN_AT) begin
        wait_for_answers();
      end
      c.x      = COORD_W'($urandom());
      c.y      = COORD_W'($urandom());
      c.parent = PARENT_W'($urandom());
      c.index  = IDX_W'($urandom());
      pick     = $urandom_range(0, 99);
      if (pick < 32) begin
        c.func = FUNC_INSERT;
        if (fill_count > 0 && $urandom_range(0, 7) == 0) begin
          k   = $urandom_range(0, fill_count - 1);
          c.x = pt_x[k];
          c.y = pt_y[k];
        end else begin
          c.x = pick_coord();
          c.y = pick_coord();
        end
      end else if (pick < 67) begin
        c.func = FUNC_NEAREST;
        if (fill_count > 0 && $urandom_range(0, 1) == 0) begin
          k   = $urandom_range(0, fill_count - 1);
          c.x = pt_x[k] + COORD_W'(int'($urandom_range(0, 6)) - 3);
          c.y = pt_y[k] + COORD_W'(int'($urandom_range(0, 6)) - 3);
        end else if ($urandom_range(0, 1) == 0) begin
          c.x = pick_coord();
          c.y = pick_coord();
        end
      end else if (pick < 95) begin
        c.func = FUNC_READ;
        if (fill_count > 0 && $urandom_range(0, 4) != 0) begin
          c.index = IDX_W'($urandom_range(0, fill_count - 1));
        end
      end else begin
        c.func = FUNC_UNUSED;
      end
      issue(c, idle_gap(), 1'b0, '0);
    end

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
